/* rtl/shs_pkg.sv */
// Shared types, codes and constants of the streaming SHA-256 hasher.
// Used by the controller, the datapath and the top level.
// Depends on nothing.
`timescale 1ns / 1ps

package shs_pkg;

  // Input opcodes
  localparam logic [1:0] OPC_START  = 2'd0;
  localparam logic [1:0] OPC_ABSORB = 2'd1;
  localparam logic [1:0] OPC_FINISH = 2'd2;

  // Datapath commands
  localparam logic [3:0] DP_NOP       = 4'd0;
  localparam logic [3:0] DP_INIT      = 4'd1;
  localparam logic [3:0] DP_ABSORB    = 4'd2;
  localparam logic [3:0] DP_PAD       = 4'd3;
  localparam logic [3:0] DP_LEN       = 4'd4;
  localparam logic [3:0] DP_PREP      = 4'd5;
  localparam logic [3:0] DP_ROUND     = 4'd6;
  localparam logic [3:0] DP_FOLD      = 4'd7;
  localparam logic [3:0] DP_EMIT      = 4'd8;
  localparam logic [3:0] DP_EMIT_LAST = 4'd9;

  localparam logic [5:0] LAST_ROUND  = 6'd63;
  localparam logic [5:0] LAST_BYTE   = 6'd63;
  localparam logic [5:0] LEN_SLOT    = 6'd56;  // first byte of the length field
  localparam logic [5:0] MSG_WORDS   = 6'd16;
  localparam logic [2:0] LAST_WORD   = 3'd7;
  localparam logic [7:0] PAD_MARK    = 8'h80;

  typedef struct packed {
    logic [3:0] op;
    logic [5:0] rnd;
    logic [2:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       out_free;
  } dp_sts_t;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

/* rtl/shs_if.sv */
// Channel interfaces of the hasher: command input and digest word output.
// Depends on nothing.
`timescale 1ns / 1ps

interface shs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] data_byte;

  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

interface shs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

/* rtl/shs_datapath.sv */
// Datapath: hash words, round variables, block buffer / schedule window,
// counters and the output register. Driven by commands from shs_ctrl; uses shs_pkg.
`timescale 1ns / 1ps

module shs_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  shs_pkg::dp_cmd_t      cmd,
  input  logic [7:0]            data_byte,
  input  logic                  out_ready,
  output shs_pkg::dp_sts_t      sts,
  output logic                  out_valid,
  output logic [31:0]           out_digest_word,
  output logic [2:0]            out_word_index,
  output logic                  out_last_word
);

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  logic [31:0] hash_r   [8];
  logic [31:0] hash_nxt [8];
  logic [31:0] var_r    [8];
  logic [31:0] var_nxt  [8];
  logic [31:0] sched_r  [16];
  logic [31:0] sched_nxt[16];
  logic [31:0] kw_r, kw_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [54:0] blk_r, blk_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_word_r, out_word_nxt;
  logic [2:0]  out_idx_r, out_idx_nxt;
  logic        out_last_r, out_last_nxt;

  logic [31:0] w_gen, w_next;
  logic [63:0] total_bits;
  logic [5:0]  rnd_inc;
  logic [31:0] big0, big1, choose, major, t1, t2;
  logic [5:0]  pos;

  always_comb begin
    w_gen = (rotr(sched_r[14], 17) ^ rotr(sched_r[14], 19) ^ (sched_r[14] >> 10))
          + sched_r[9]
          + (rotr(sched_r[1], 7) ^ rotr(sched_r[1], 18) ^ (sched_r[1] >> 3))
          + sched_r[0];
    w_next = (cmd.rnd < (shs_pkg::MSG_WORDS - 6'd1)) ? sched_r[0] : w_gen;
    rnd_inc = cmd.rnd + 6'd1;
    // Completed blocks are multiples of 512 bits, so the sum needs no adder.
    total_bits = {blk_r, fill_r, 3'b000};

    big1   = rotr(var_r[4], 6) ^ rotr(var_r[4], 11) ^ rotr(var_r[4], 25);
    choose = (var_r[4] & var_r[5]) ^ (~var_r[4] & var_r[6]);
    t1     = var_r[7] + big1 + choose + kw_r;
    big0   = rotr(var_r[0], 2) ^ rotr(var_r[0], 13) ^ rotr(var_r[0], 22);
    major  = (var_r[0] & var_r[1]) ^ (var_r[0] & var_r[2]) ^ (var_r[1] & var_r[2]);
    t2     = big0 + major;

    hash_nxt      = hash_r;
    var_nxt       = var_r;
    sched_nxt     = sched_r;
    kw_nxt        = kw_r;
    fill_nxt      = fill_r;
    blk_nxt       = blk_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    pos           = '0;

    unique case (cmd.op)
      shs_pkg::DP_NOP: begin
      end
      shs_pkg::DP_INIT: begin
        hash_nxt = shs_pkg::H_INIT;
        fill_nxt = '0;
        blk_nxt  = '0;
      end
      shs_pkg::DP_ABSORB: begin
        // Bytes land big-endian within each schedule word.
        case (fill_r[1:0])
          2'd0:    sched_nxt[fill_r[5:2]][31:24] = data_byte;
          2'd1:    sched_nxt[fill_r[5:2]][23:16] = data_byte;
          2'd2:    sched_nxt[fill_r[5:2]][15:8]  = data_byte;
          default: sched_nxt[fill_r[5:2]][7:0]   = data_byte;
        endcase
        fill_nxt = fill_r + 6'd1;
        if (fill_r == shs_pkg::LAST_BYTE) begin
          blk_nxt = blk_r + 55'd1;
        end
      end
      shs_pkg::DP_PAD: begin
        // Keep pending bytes, mark the end, zero the rest, length if it fits.
        for (int w = 0; w < 16; w++) begin
          for (int l = 0; l < 4; l++) begin
            pos = 6'(w * 4 + l);
            if (pos < fill_r) begin
              sched_nxt[w][8*(3-l) +: 8] = sched_r[w][8*(3-l) +: 8];
            end else if (pos == fill_r) begin
              sched_nxt[w][8*(3-l) +: 8] = shs_pkg::PAD_MARK;
            end else if (fill_r < shs_pkg::LEN_SLOT && pos >= shs_pkg::LEN_SLOT) begin
              sched_nxt[w][8*(3-l) +: 8] = total_bits[{3'd7 - pos[2:0], 3'b000} +: 8];
            end else begin
              sched_nxt[w][8*(3-l) +: 8] = 8'h00;
            end
          end
        end
      end
      shs_pkg::DP_LEN: begin
        for (int w = 0; w < 14; w++) begin
          sched_nxt[w] = '0;
        end
        sched_nxt[14] = total_bits[63:32];
        sched_nxt[15] = total_bits[31:0];
      end
      shs_pkg::DP_PREP: begin
        var_nxt = hash_r;
        kw_nxt  = shs_pkg::K_TAB[0] + sched_r[0];
        for (int i = 0; i < 15; i++) begin
          sched_nxt[i] = sched_r[i+1];
        end
        sched_nxt[15] = sched_r[0];
      end
      shs_pkg::DP_ROUND: begin
        var_nxt[7] = var_r[6];
        var_nxt[6] = var_r[5];
        var_nxt[5] = var_r[4];
        var_nxt[4] = var_r[3] + t1;
        var_nxt[3] = var_r[2];
        var_nxt[2] = var_r[1];
        var_nxt[1] = var_r[0];
        var_nxt[0] = t1 + t2;
        // Prepare K + W for the following round.
        kw_nxt = shs_pkg::K_TAB[rnd_inc] + w_next;
        for (int i = 0; i < 15; i++) begin
          sched_nxt[i] = sched_r[i+1];
        end
        sched_nxt[15] = w_next;
      end
      shs_pkg::DP_FOLD: begin
        for (int j = 0; j < 8; j++) begin
          hash_nxt[j] = hash_r[j] + var_r[j];
        end
      end
      shs_pkg::DP_EMIT, shs_pkg::DP_EMIT_LAST: begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = hash_r[cmd.idx];
        out_idx_nxt   = cmd.idx;
        out_last_nxt  = (cmd.op == shs_pkg::DP_EMIT_LAST);
        if (cmd.op == shs_pkg::DP_EMIT_LAST) begin
          hash_nxt = shs_pkg::H_INIT;
          fill_nxt = '0;
          blk_nxt  = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r      <= shs_pkg::H_INIT;
      fill_r      <= '0;
      blk_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      hash_r      <= hash_nxt;
      fill_r      <= fill_nxt;
      blk_r       <= blk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    var_r      <= var_nxt;
    sched_r    <= sched_nxt;
    kw_r       <= kw_nxt;
    out_word_r <= out_word_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

  assign sts.fill        = fill_r;
  assign sts.out_free    = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_index  = out_idx_r;
  assign out_last_word   = out_last_r;

endmodule

/* rtl/shs_ctrl.sv */
// Controller: sequences absorb, padding, the 64 rounds and digest output.
// Issues commands to shs_datapath and reads its status; uses shs_pkg.
`timescale 1ns / 1ps

module shs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_opcode,
  input  shs_pkg::dp_sts_t  sts,
  output logic              in_ready,
  output shs_pkg::dp_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_FOLD  = 3'd3;
  localparam logic [2:0] ST_LEN   = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       fin_r, fin_nxt;   // compression belongs to a finish
  logic       two_r, two_nxt;   // a length-only block still follows
  logic       accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    idx_nxt   = idx_r;
    fin_nxt   = fin_r;
    two_nxt   = two_r;
    cmd.op    = shs_pkg::DP_NOP;
    cmd.rnd   = rnd_r;
    cmd.idx   = idx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_opcode)
            shs_pkg::OPC_START: begin
              cmd.op = shs_pkg::DP_INIT;
            end
            shs_pkg::OPC_ABSORB: begin
              cmd.op = shs_pkg::DP_ABSORB;
              if (sts.fill == shs_pkg::LAST_BYTE) begin
                fin_nxt   = 1'b0;
                state_nxt = ST_PREP;
              end
            end
            shs_pkg::OPC_FINISH: begin
              cmd.op    = shs_pkg::DP_PAD;
              fin_nxt   = 1'b1;
              two_nxt   = (sts.fill >= shs_pkg::LEN_SLOT);
              state_nxt = ST_PREP;
            end
            default: begin
            end
          endcase
        end
      end
      ST_PREP: begin
        cmd.op    = shs_pkg::DP_PREP;
        rnd_nxt   = '0;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.op  = shs_pkg::DP_ROUND;
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == shs_pkg::LAST_ROUND) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.op = shs_pkg::DP_FOLD;
        if (!fin_r) begin
          state_nxt = ST_IDLE;
        end else if (two_r) begin
          two_nxt   = 1'b0;
          state_nxt = ST_LEN;
        end else begin
          idx_nxt   = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_LEN: begin
        cmd.op    = shs_pkg::DP_LEN;
        state_nxt = ST_PREP;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          if (idx_r == shs_pkg::LAST_WORD) begin
            cmd.op    = shs_pkg::DP_EMIT_LAST;
            fin_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            cmd.op  = shs_pkg::DP_EMIT;
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rnd_r   <= '0;
      idx_r   <= '0;
      fin_r   <= 1'b0;
      two_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
      fin_r   <= fin_nxt;
      two_r   <= two_nxt;
    end
  end

endmodule

/* rtl/sha256_stream_hasher_top.sv */
// Top level of the streaming SHA-256 hasher: controller plus datapath.
// Depends on shs_pkg, shs_if, shs_ctrl and shs_datapath.
//
//   channel  | dir | handshake           | payload
//   ---------+-----+---------------------+----------------------------------
//   in_ch    | in  | valid/ready         | opcode[1:0], data_byte[7:0]
//   out_ch   | out | valid/ready         | digest_word[31:0], word_index[2:0],
//            |     |                     | last_word
//
// Start, plain absorb and unused opcodes are taken while idle and leave the
// controller idle. The absorb that completes a 64-byte block runs a load, the
// 64 rounds and a fold on the single round unit. Finish does so for the padded
// block, and again for a length-only block when the length does not fit, then
// gives eight digest words, one per cycle while the output side takes them.
// Reset loads the initial hash and clears the counters; no clearing pass.
// A stalled output holds the digest sequence; input stays stalled until the
// last word sits in the output register, which then no longer blocks input.
`timescale 1ns / 1ps

module sha256_stream_hasher_top (
  input  logic             clk,
  input  logic             rst_n,
  shs_in_if.sink           in_ch,
  shs_out_if.source        out_ch
);

  shs_pkg::dp_cmd_t cmd;
  shs_pkg::dp_sts_t sts;
  logic             in_ready;

  // Sequence the work: one item at a time, ready only while idle.
  shs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .sts       (sts),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  assign in_ch.ready = in_ready;

  // Hold state, run the rounds and drive the output register.
  shs_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .data_byte       (in_ch.data_byte),
    .out_ready       (out_ch.ready),
    .sts             (sts),
    .out_valid       (out_ch.valid),
    .out_digest_word (out_ch.digest_word),
    .out_word_index  (out_ch.word_index),
    .out_last_word   (out_ch.last_word)
  );

endmodule

/* rtl/shs_checker.sv */
// Port-level checks of the hasher, bound to sha256_stream_hasher_top.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module shs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_last_word
);

  logic [2:0] exp_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_idx_r <= '0;
    end else if (out_valid && out_ready) begin
      exp_idx_r <= out_last_word ? 3'd0 : out_word_index + 3'd1;
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digest_word)
                                && $stable(out_word_index))
    else $error("stalled digest word changed");

  a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word_index == exp_idx_r)
    else $error("digest word out of order");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_last_word == (out_word_index == 3'd7))
    else $error("last flag not on the eighth word");

  a_no_input_mid_digest: assert property (@(posedge clk) disable iff (!rst_n)
    exp_idx_r != 3'd0 && exp_idx_r != 3'd7 |-> !in_ready)
    else $error("input taken while a digest is being sent");

endmodule

bind sha256_stream_hasher_top shs_checker u_shs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_digest_word (out_ch.digest_word),
  .out_word_index  (out_ch.word_index),
  .out_last_word   (out_ch.last_word)
);
